### src/gregorian_date_day_offset_top_assert.svh
// Assertion macros for the date offset block checker.
`ifndef GREGORIAN_DATE_DAY_OFFSET_TOP_ASSERT_SVH
`define GREGORIAN_DATE_DAY_OFFSET_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GDO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdo_chk: same-cycle property violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GDO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdo_chk: next-cycle property violated");

`endif

### src/gdo_pkg.sv
// Shared types, constants and calendar tables for the date offset block.
`default_nettype none

package gdo_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 21;
    localparam int SERIAL_W = 22;
    localparam int TOTAL_W  = 22;
    localparam int DOY_W    = 9;
    localparam int CENT_W   = 7;
    localparam int DIV100_W = 13;
    localparam int DIV100_SHIFT = 19;

    localparam logic [YEAR_W-1:0]   YEAR_MIN     = 14'd1;
    localparam logic [YEAR_W-1:0]   YEAR_MAX     = 14'd9999;
    localparam logic [DOY_W-1:0]    DAYS_COMMON  = 9'd365;
    localparam logic [DIV100_W-1:0] DIV100_RECIP = 13'd5243;
    localparam logic [CENT_W-1:0]   CENT_LAST    = 7'd99;
    localparam logic [YEAR_W-1:0]   CENT_YEARS   = 14'd100;
    localparam logic [MONTH_W-1:0]  LAST_MONTH   = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SPLIT,
        S_ORD,
        S_BACK,
        S_FWD,
        S_SUM,
        S_MONTH,
        S_ERR
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_REM,
        OP_ORD,
        OP_DEC,
        OP_INC,
        OP_SPAN,
        OP_SUM,
        OP_MONTH,
        OP_FIN_OK,
        OP_FIN_ERR
    } t_dp_op;

    typedef struct packed {
        logic year_bad;
        logic total_low;
        logic year_first;
        logic total_high;
        logic year_last;
        logic month_more;
    } t_dp_status;

    // Leap year from the year split into centuries and the year within the century.
    function automatic logic is_leap(input logic [CENT_W-1:0] cent,
                                     input logic [CENT_W-1:0] rest);
        return (rest[1:0] == 2'b00) && ((rest != '0) || (cent[1:0] == 2'b00));
    endfunction

    function automatic logic [DOY_W-1:0] year_len(input logic leap);
        return DAYS_COMMON + {{(DOY_W-1){1'b0}}, leap};
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the first n months of a common year; twelve or more gives the whole year.
    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] n);
        logic [DOY_W-1:0] sum;
        unique case (n)
            4'd0:    sum = 9'd0;
            4'd1:    sum = 9'd31;
            4'd2:    sum = 9'd59;
            4'd3:    sum = 9'd90;
            4'd4:    sum = 9'd120;
            4'd5:    sum = 9'd151;
            4'd6:    sum = 9'd181;
            4'd7:    sum = 9'd212;
            4'd8:    sum = 9'd243;
            4'd9:    sum = 9'd273;
            4'd10:   sum = 9'd304;
            4'd11:   sum = 9'd334;
            default: sum = 9'd365;
        endcase
        return sum;
    endfunction

endpackage

`default_nettype wire

### src/gdo_ctrl.sv
// Controller state machine that sequences the date offset datapath.
`default_nettype none

module gdo_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  gdo_pkg::t_dp_status i_status,
    output gdo_pkg::t_dp_op     o_op,
    output logic                o_busy,
    output logic                o_done
);
    import gdo_pkg::*;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = OP_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.year_bad) begin
                    n_state = S_ERR;
                end else begin
                    o_op    = OP_DIV;
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                o_op    = OP_REM;
                n_state = S_ORD;
            end
            S_ORD: begin
                o_op    = OP_ORD;
                n_state = S_BACK;
            end
            S_BACK: begin
                if (i_status.total_low) begin
                    if (i_status.year_first) begin
                        n_state = S_ERR;
                    end else begin
                        o_op = OP_DEC;
                    end
                end else begin
                    n_state = S_FWD;
                end
            end
            S_FWD: begin
                if (i_status.total_high) begin
                    if (i_status.year_last) begin
                        n_state = S_ERR;
                    end else begin
                        o_op = OP_INC;
                    end
                end else begin
                    o_op    = OP_SPAN;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_op    = OP_SUM;
                n_state = S_MONTH;
            end
            S_MONTH: begin
                if (i_status.month_more) begin
                    o_op = OP_MONTH;
                end else begin
                    o_op    = OP_FIN_OK;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                o_op    = OP_FIN_ERR;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

### src/gdo_dp.sv
// Datapath of the date offset block: year and month stepping and serial day sum.
`default_nettype none

module gdo_dp #(
    parameter int EPOCH_YEAR = 1900
) (
    input  logic                                  i_clk,
    input  gdo_pkg::t_dp_op                       i_op,
    output gdo_pkg::t_dp_status                   o_status,
    input  logic        [gdo_pkg::YEAR_W-1:0]     i_year_in,
    input  logic        [gdo_pkg::MONTH_W-1:0]    i_month_in,
    input  logic        [gdo_pkg::DAY_W-1:0]      i_day_in,
    input  logic signed [gdo_pkg::OFFSET_W-1:0]   i_day_offset,
    output logic        [gdo_pkg::YEAR_W-1:0]     o_year_out,
    output logic        [gdo_pkg::MONTH_W-1:0]    o_month_out,
    output logic        [gdo_pkg::DAY_W-1:0]      o_day_out,
    output logic        [gdo_pkg::SERIAL_W-1:0]   o_serial_day,
    output logic                                  o_serial_valid,
    output logic                                  o_range_error
);
    import gdo_pkg::*;

    // Days from year 1 up to the start of the epoch year.
    localparam int EPOCH_PREV = EPOCH_YEAR - 1;
    localparam int EPOCH_DAYS = 365 * EPOCH_PREV + EPOCH_PREV / 4 - EPOCH_PREV / 100
                                + EPOCH_PREV / 400;
    localparam logic [YEAR_W-1:0]   EPOCH     = YEAR_W'(EPOCH_YEAR);
    localparam logic [SERIAL_W-1:0] EPOCH_OFS = SERIAL_W'(EPOCH_DAYS);

    logic        [YEAR_W-1:0]   r_year_in;
    logic        [MONTH_W-1:0]  r_month_in;
    logic        [DAY_W-1:0]    r_day_in;
    logic signed [OFFSET_W-1:0] r_offset;
    logic        [YEAR_W-1:0]   r_year;
    logic        [CENT_W-1:0]   r_cent;
    logic        [CENT_W-1:0]   r_rest;
    logic signed [TOTAL_W-1:0]  r_total;
    logic        [MONTH_W-1:0]  r_month;
    logic        [DOY_W-1:0]    r_doy;
    logic        [SERIAL_W-1:0] r_span;

    logic        [YEAR_W+DIV100_W-1:0] w_prod;
    logic        [YEAR_W-1:0]   w_rem;
    logic                       w_leap;
    logic        [DOY_W-1:0]    w_ylen;
    logic signed [TOTAL_W-1:0]  w_ylen_s;
    logic        [CENT_W-1:0]   w_dec_cent, w_dec_rest, w_inc_cent, w_inc_rest;
    logic signed [TOTAL_W-1:0]  w_dec_len_s;
    logic        [MONTH_W-1:0]  w_lim;
    logic        [DOY_W-1:0]    w_ord;
    logic signed [TOTAL_W-1:0]  w_ord_sum;
    logic        [DAY_W-1:0]    w_mlen;
    logic signed [TOTAL_W-1:0]  w_mlen_s;
    logic        [YEAR_W-1:0]   w_year_prev;
    logic        [YEAR_W-1:0]   w_leaps;
    logic        [SERIAL_W-1:0] w_doy_ext;

    // Year divided by 100 through a scaled reciprocal; exact for years up to 9999.
    assign w_prod = {{DIV100_W{1'b0}}, r_year} * {{YEAR_W{1'b0}}, DIV100_RECIP};
    assign w_rem  = r_year - ({{(YEAR_W-CENT_W){1'b0}}, r_cent} * CENT_YEARS);

    assign w_leap   = is_leap(r_cent, r_rest);
    assign w_ylen   = year_len(w_leap);
    assign w_ylen_s = $signed({{(TOTAL_W-DOY_W){1'b0}}, w_ylen});

    assign w_dec_rest  = (r_rest == '0) ? CENT_LAST : r_rest - 7'd1;
    assign w_dec_cent  = (r_rest == '0) ? r_cent - 7'd1 : r_cent;
    assign w_dec_len_s = $signed({{(TOTAL_W-DOY_W){1'b0}},
                                  year_len(is_leap(w_dec_cent, w_dec_rest))});
    assign w_inc_rest  = (r_rest == CENT_LAST) ? '0 : r_rest + 7'd1;
    assign w_inc_cent  = (r_rest == CENT_LAST) ? r_cent + 7'd1 : r_cent;

    // Month zero counts no earlier months; months past December count the whole year.
    always_comb begin
        if (r_month_in == '0) begin
            w_lim = '0;
        end else if (r_month_in > LAST_MONTH) begin
            w_lim = LAST_MONTH;
        end else begin
            w_lim = r_month_in - 4'd1;
        end
    end

    assign w_ord = {{(DOY_W-DAY_W){1'b0}}, r_day_in} + cum_days(w_lim)
                   + {{(DOY_W-1){1'b0}}, (w_lim >= 4'd2) & w_leap};
    assign w_ord_sum = $signed({{(TOTAL_W-DOY_W){1'b0}}, w_ord})
                       + $signed({r_offset[OFFSET_W-1], r_offset});

    assign w_mlen   = month_len(r_month, w_leap);
    assign w_mlen_s = $signed({{(TOTAL_W-DAY_W){1'b0}}, w_mlen});

    // Leap days among years 1 .. year-1: q/4 - q/100 + q/400 with q = year-1.
    assign w_year_prev = r_year - 14'd1;
    assign w_leaps = {2'b00, w_year_prev[YEAR_W-1:2]}
                     - {{(YEAR_W-CENT_W){1'b0}}, w_dec_cent}
                     + {{(YEAR_W-CENT_W+2){1'b0}}, w_dec_cent[CENT_W-1:2]};
    assign w_doy_ext = {{(SERIAL_W-DOY_W){1'b0}}, r_doy};

    assign o_status.year_bad   = (r_year < YEAR_MIN) || (r_year > YEAR_MAX);
    assign o_status.total_low  = r_total[TOTAL_W-1] || (r_total == '0);
    assign o_status.year_first = (r_year <= YEAR_MIN);
    assign o_status.total_high = (r_total > w_ylen_s);
    assign o_status.year_last  = (r_year >= YEAR_MAX);
    assign o_status.month_more = (r_month < LAST_MONTH) && (r_total > w_mlen_s);

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_year_in  <= i_year_in;
                r_month_in <= i_month_in;
                r_day_in   <= i_day_in;
                r_offset   <= i_day_offset;
                r_year     <= i_year_in;
                r_month    <= 4'd1;
            end
            OP_DIV: begin
                r_cent <= w_prod[DIV100_SHIFT +: CENT_W];
            end
            OP_REM: begin
                r_rest <= w_rem[CENT_W-1:0];
            end
            OP_ORD: begin
                r_total <= w_ord_sum;
            end
            OP_DEC: begin
                r_year  <= w_year_prev;
                r_cent  <= w_dec_cent;
                r_rest  <= w_dec_rest;
                r_total <= r_total + w_dec_len_s;
            end
            OP_INC: begin
                r_year  <= r_year + 14'd1;
                r_cent  <= w_inc_cent;
                r_rest  <= w_inc_rest;
                r_total <= r_total - w_ylen_s;
            end
            OP_SPAN: begin
                r_doy  <= r_total[DOY_W-1:0];
                r_span <= {{(SERIAL_W-YEAR_W){1'b0}}, w_year_prev}
                          * {{(SERIAL_W-DOY_W){1'b0}}, DAYS_COMMON};
            end
            OP_SUM: begin
                r_span <= r_span + {{(SERIAL_W-YEAR_W){1'b0}}, w_leaps} - EPOCH_OFS;
            end
            OP_MONTH: begin
                r_total <= r_total - w_mlen_s;
                r_month <= r_month + 4'd1;
            end
            OP_FIN_OK: begin
                o_year_out     <= r_year;
                o_month_out    <= r_month;
                o_day_out      <= r_total[DAY_W-1:0];
                o_serial_day   <= (r_year >= EPOCH) ? r_span + w_doy_ext : w_doy_ext;
                o_serial_valid <= (r_year >= EPOCH);
                o_range_error  <= 1'b0;
            end
            OP_FIN_ERR: begin
                o_year_out     <= r_year_in;
                o_month_out    <= r_month_in;
                o_day_out      <= r_day_in;
                o_serial_day   <= '0;
                o_serial_valid <= 1'b0;
                o_range_error  <= 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### src/gregorian_date_day_offset_top.sv
// Top level of the Gregorian date plus day offset block.
//
// Channel   Direction  Handshake            Payload
// command   in         start, busy          i_year_in, i_month_in, i_day_in, i_day_offset
// result    out        o_valid (strobe)     o_year_out, o_month_out, o_day_out,
//                                           o_serial_day, o_serial_valid, o_range_error
//
// A command transfer happens at a rising edge where start is high and busy is low.
// The block then works on that one date and raises busy until the result is ready.
// For a valid start date the work grows with Y, the number of whole years stepped (at most
// about 2872 for the full offset range), and M, the number of months stepped (at most 11).
// The year stepping loop moves one year per cycle, adding a year length to or taking one
// from the running day total, and it is the longest part of the work.
// A start year outside 1..9999 is caught in the check state and gives its error result.
// The result is shown for one cycle with o_valid and the receiver cannot stall it.
// Reset is synchronous and active low; it returns the controller to idle.
`default_nettype none

module gregorian_date_day_offset_top #(
    parameter int EPOCH_YEAR = 1900
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [gdo_pkg::YEAR_W-1:0]     i_year_in,
    input  logic        [gdo_pkg::MONTH_W-1:0]    i_month_in,
    input  logic        [gdo_pkg::DAY_W-1:0]      i_day_in,
    input  logic signed [gdo_pkg::OFFSET_W-1:0]   i_day_offset,
    output logic                                  o_valid,
    output logic        [gdo_pkg::YEAR_W-1:0]     o_year_out,
    output logic        [gdo_pkg::MONTH_W-1:0]    o_month_out,
    output logic        [gdo_pkg::DAY_W-1:0]      o_day_out,
    output logic        [gdo_pkg::SERIAL_W-1:0]   o_serial_day,
    output logic                                  o_serial_valid,
    output logic                                  o_range_error
);
    import gdo_pkg::*;

    // The controller only sees status flags and only issues one datapath operation a cycle.
    t_dp_op     w_op;
    t_dp_status w_status;

    gdo_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_op     (w_op),
        .o_busy   (busy),
        .o_done   (o_valid)
    );

    // The datapath holds the working year split into century and year within the century,
    // so the leap rule needs no division while the years are stepped.
    gdo_dp #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_dp (
        .i_clk          (i_clk),
        .i_op           (w_op),
        .o_status       (w_status),
        .i_year_in      (i_year_in),
        .i_month_in     (i_month_in),
        .i_day_in       (i_day_in),
        .i_day_offset   (i_day_offset),
        .o_year_out     (o_year_out),
        .o_month_out    (o_month_out),
        .o_day_out      (o_day_out),
        .o_serial_day   (o_serial_day),
        .o_serial_valid (o_serial_valid),
        .o_range_error  (o_range_error)
    );

endmodule

`default_nettype wire

### src/gdo_chk.sv
// Port-level checker for the date offset block and its bind to the top level.
`default_nettype none

`include "gregorian_date_day_offset_top_assert.svh"

module gdo_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic        [gdo_pkg::YEAR_W-1:0]     i_year_in,
    input logic        [gdo_pkg::MONTH_W-1:0]    i_month_in,
    input logic        [gdo_pkg::DAY_W-1:0]      i_day_in,
    input logic signed [gdo_pkg::OFFSET_W-1:0]   i_day_offset,
    input logic                                  o_valid,
    input logic        [gdo_pkg::YEAR_W-1:0]     o_year_out,
    input logic        [gdo_pkg::MONTH_W-1:0]    o_month_out,
    input logic        [gdo_pkg::DAY_W-1:0]      o_day_out,
    input logic        [gdo_pkg::SERIAL_W-1:0]   o_serial_day,
    input logic                                  o_serial_valid,
    input logic                                  o_range_error
);
    import gdo_pkg::*;

    // A transfer always starts work.
    `GDO_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // A result comes only at the end of work and never twice in a row.
    `GDO_ASSERT_NOW(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(busy))
    `GDO_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)

    // An error result carries no serial day; a good result is a real calendar date.
    `GDO_ASSERT_NOW(a_err_serial, i_clk, i_rst_n, o_valid && o_range_error, (o_serial_day == '0) && !o_serial_valid)
    `GDO_ASSERT_NOW(a_ok_date, i_clk, i_rst_n, o_valid && !o_range_error, (o_month_out != '0) && (o_month_out <= LAST_MONTH) && (o_day_out != '0) && (o_year_out != '0))

endmodule

bind gregorian_date_day_offset_top gdo_chk u_gdo_chk (.*);

`default_nettype wire
